@@ hw/rtl/hfa_pkg.sv @@
// Shared types and constants of the hemicube form-factor accumulator.
`default_nettype none
package hfa_pkg;

    localparam int MODE_W  = 2;
    localparam int CODE_W  = 24;
    localparam int COORD_W = 6;
    localparam int ENTRY_W = 10;
    localparam int FF_W    = 16;
    localparam int PC_W    = 11;
    localparam int ACC_W   = 32;
    localparam int DIV_W   = 64;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACCUM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [FF_W-1:0]  FF_MAX  = 16'hFFFF;
    localparam logic [ACC_W-1:0] ACC_MAX = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic geo1;
        logic geo2;
        logic geo3;
        logic start_w;
        logic start_n;
        logic bin_wr;
        logic ff_take;
        logic clr_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              hit;
        logic              rd_ok;
        logic              clr_last;
        logic              div_busy;
    } t_dp_status;

endpackage
`default_nettype wire

@@ hw/rtl/hfa_in_if.sv @@
// Input channel of the accumulator: one pixel or command word.
`default_nettype none
interface hfa_in_if
    import hfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic               side_face;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_column;
    logic [CODE_W-1:0]  color_code;
    logic [ENTRY_W-1:0] entry_index;

    modport source (output valid, mode, side_face, pixel_row, pixel_column,
                    color_code, entry_index, input ready);
    modport sink   (input valid, mode, side_face, pixel_row, pixel_column,
                    color_code, entry_index, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hfa_out_if.sv @@
// Output channel of the accumulator: one result word.
`default_nettype none
interface hfa_out_if
    import hfa_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [FF_W-1:0] form_factor;
    logic            pixel_counted;

    modport source (output valid, form_factor, pixel_counted, input ready);
    modport sink   (input valid, form_factor, pixel_counted, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hfa_divider.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module hfa_divider
    import hfa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic [DIV_W-1:0]      o_quotient
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dsr;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!diff[DIV_W]) begin
                r_rem <= diff[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

@@ hw/rtl/hfa_datapath.sv @@
// Datapath: item capture, weight geometry, bin memory, total and divider.
`default_nettype none
module hfa_datapath
    import hfa_pkg::*;
#(
    parameter int GRID_SIZE        = 64,
    parameter int MAX_PATCHES      = 1024,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [PC_W-1:0]    i_cfg_wr_data,
    input  wire logic [MODE_W-1:0]  i_mode,
    input  wire logic               i_side_face,
    input  wire logic [COORD_W-1:0] i_pixel_row,
    input  wire logic [COORD_W-1:0] i_pixel_column,
    input  wire logic [CODE_W-1:0]  i_color_code,
    input  wire logic [ENTRY_W-1:0] i_entry_index,
    output logic [FF_W-1:0]         o_form_factor,
    output logic                    o_pixel_counted
);
    localparam int AW   = $clog2(MAX_PATCHES);
    localparam int GW   = $clog2(GRID_SIZE) + 1;
    localparam int SW   = 2 * GW + 2;
    localparam int HALF = GRID_SIZE / 2;
    localparam int WF   = WEIGHT_FRAC_BITS;
    localparam longint unsigned G64     = longint'(GRID_SIZE);
    localparam longint unsigned G3      = G64 * G64 * G64;
    localparam logic [DIV_W-1:0] NUM_TOP = DIV_W'((G64 * G3) << WF);
    localparam logic [SW-1:0]    G_SQ    = SW'(G64 * G64);
    localparam logic [DIV_W-1:0] W_MAX   = DIV_W'((64'd1 << WF) - 64'd1);

    // Captured item.
    logic [MODE_W-1:0]  r_mode;
    logic               r_side;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic [CODE_W-1:0]  r_code;
    logic [ENTRY_W-1:0] r_entry;
    logic [PC_W-1:0]    r_patch_count;

    logic [ACC_W-1:0]   r_bins [MAX_PATCHES];
    logic [ACC_W-1:0]   r_rdata;
    logic [ACC_W-1:0]   r_total;
    logic [AW-1:0]      r_clr_cnt;

    logic [2*GW-1:0]    r_asq;
    logic [2*GW-1:0]    r_bsq;
    logic [SW-1:0]      r_s;
    logic [2*SW-1:0]    r_den;
    logic [DIV_W-1:0]   r_num;

    logic [FF_W-1:0]    r_ff_pend;
    logic               r_cnt_pend;

    logic [CODE_W-1:0]  idx;
    logic [CODE_W-1:0]  entry_ext;
    logic [AW-1:0]      rd_addr;
    logic               row_ok;
    logic               col_ok;
    logic               side_ok;
    logic signed [GW+1:0]   a_val;
    logic signed [GW+1:0]   b_val;
    logic signed [GW+1:0]   c_val;
    logic signed [2*GW+3:0] a_prod;
    logic signed [2*GW+3:0] b_prod;
    logic signed [2*GW+3:0] c_prod;
    logic [DIV_W-1:0]   side_num;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_busy;
    logic [DIV_W-1:0]   div_q;
    logic [ACC_W-1:0]   weight;
    logic [ACC_W:0]     bin_sum;
    logic [ACC_W:0]     tot_sum;
    logic [ACC_W-1:0]   bin_sat;
    logic [ACC_W-1:0]   tot_sat;
    logic [FF_W-1:0]    ff_sat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_side  <= i_side_face;
            r_row   <= i_pixel_row;
            r_col   <= i_pixel_column;
            r_code  <= i_color_code;
            r_entry <= i_entry_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_count <= PC_W'(1);
        end else if (i_cfg_wr_en) begin
            r_patch_count <= i_cfg_wr_data;
        end
    end

    // Hit test on the captured pixel.
    assign idx       = r_code - CODE_W'(1);
    assign entry_ext = CODE_W'(r_entry);
    assign row_ok    = (10'(r_row) < 10'(GRID_SIZE));
    assign col_ok    = (10'(r_col) < 10'(GRID_SIZE));
    assign side_ok   = !r_side ||
                       ((10'(r_row) >= 10'(HALF)) && (10'(r_row) - 10'(HALF) < 10'(HALF)));

    assign o_status.mode     = r_mode;
    assign o_status.hit      = (r_code != '0) && row_ok && col_ok && side_ok &&
                               (idx < CODE_W'(r_patch_count)) &&
                               (idx < CODE_W'(MAX_PATCHES));
    assign o_status.rd_ok    = (entry_ext < CODE_W'(MAX_PATCHES)) && (r_total != '0);
    assign o_status.clr_last = (r_clr_cnt == AW'(MAX_PATCHES - 1));
    assign o_status.div_busy = div_busy;

    // Geometry: signed offsets from the face center, their squares, then S and S squared.
    assign a_val  = $signed((GW+2)'({r_col, 1'b1})) - $signed((GW+2)'(GRID_SIZE));
    assign b_val  = $signed((GW+2)'({r_row, 1'b1})) - $signed((GW+2)'(GRID_SIZE));
    assign c_val  = $signed((GW+2)'({r_row, 1'b1})) - $signed((GW+2)'(2 * HALF));
    assign a_prod = a_val * a_val;
    assign b_prod = b_val * b_val;
    assign c_prod = c_val * c_val;
    assign side_num = (DIV_W'(c_val[GW-1:0]) * DIV_W'(G3)) << WF;

    always_ff @(posedge i_clk) begin
        if (i_cmd.geo1) begin
            r_asq <= a_prod[2*GW-1:0];
            r_bsq <= r_side ? c_prod[2*GW-1:0] : b_prod[2*GW-1:0];
            r_num <= r_side ? side_num : NUM_TOP;
        end
        if (i_cmd.geo2) begin
            r_s <= SW'(r_asq) + SW'(r_bsq) + G_SQ;
        end
        if (i_cmd.geo3) begin
            r_den <= r_s * r_s;
        end
    end

    // Shared divider: weight rounding or bin normalization.
    assign div_dividend = i_cmd.start_w ? (r_num + (DIV_W'(r_den) >> 1))
                                        : DIV_W'({r_rdata, 16'h0000});
    assign div_divisor  = i_cmd.start_w ? DIV_W'(r_den) : DIV_W'(r_total);

    hfa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_w | i_cmd.start_n),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign weight  = (div_q > W_MAX) ? ACC_W'(W_MAX) : ACC_W'(div_q[WF-1:0]);
    assign bin_sum = {1'b0, r_rdata} + {1'b0, weight};
    assign tot_sum = {1'b0, r_total} + {1'b0, weight};
    assign bin_sat = bin_sum[ACC_W] ? ACC_MAX : bin_sum[ACC_W-1:0];
    assign tot_sat = tot_sum[ACC_W] ? ACC_MAX : tot_sum[ACC_W-1:0];
    assign ff_sat  = (div_q > DIV_W'(FF_MAX)) ? FF_MAX : div_q[FF_W-1:0];

    // Bin memory: one write port, one registered read port.
    assign rd_addr = (r_mode == MODE_READ) ? entry_ext[AW-1:0] : idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_bins[r_clr_cnt] <= '0;
        end else if (i_cmd.bin_wr) begin
            r_bins[idx[AW-1:0]] <= bin_sat;
        end
        r_rdata <= r_bins[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_total   <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= o_status.clr_last ? '0 : r_clr_cnt + 1'b1;
            r_total   <= '0;
        end else if (i_cmd.bin_wr) begin
            r_total <= tot_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ff_pend  <= '0;
            r_cnt_pend <= 1'b0;
        end else begin
            if (i_cmd.bin_wr) begin
                r_cnt_pend <= 1'b1;
            end
            if (i_cmd.ff_take) begin
                r_ff_pend <= ff_sat;
            end
        end
        if (i_cmd.out_load) begin
            o_form_factor   <= r_ff_pend;
            o_pixel_counted <= r_cnt_pend;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/hfa_ctrl.sv @@
// Controller state machine of the accumulator.
`default_nettype none
module hfa_ctrl
    import hfa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DISPATCH, S_G1, S_G2, S_G3, S_WSTART, S_WDIV,
        S_BWR, S_NSTART, S_NDIV, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_reply;
    logic   n_reply;
    logic   out_free;

    assign out_free   = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_reply = r_reply;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = r_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.mode)
                    MODE_CLEAR: begin
                        n_reply = 1'b1;
                        n_state = S_CLR;
                    end
                    MODE_ACCUM: n_state = i_status.hit ? S_G1 : S_DONE;
                    MODE_READ:  n_state = i_status.rd_ok ? S_NSTART : S_DONE;
                    default:    n_state = S_DONE;
                endcase
            end
            S_G1: begin
                o_cmd.geo1 = 1'b1;
                n_state    = S_G2;
            end
            S_G2: begin
                o_cmd.geo2 = 1'b1;
                n_state    = S_G3;
            end
            S_G3: begin
                o_cmd.geo3 = 1'b1;
                n_state    = S_WSTART;
            end
            S_WSTART: begin
                o_cmd.start_w = 1'b1;
                n_state       = S_WDIV;
            end
            S_WDIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_BWR;
                end
            end
            S_BWR: begin
                o_cmd.bin_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_NSTART: begin
                o_cmd.start_n = 1'b1;
                n_state       = S_NDIV;
            end
            S_NDIV: begin
                if (!i_status.div_busy) begin
                    o_cmd.ff_take = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_reply     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= (n_state == S_CLR) ? n_reply : 1'b0;
            if (o_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/hemicube_form_factor_accumulator.sv @@
// Top level of the hemicube form-factor accumulator.
// The block takes one word at a time on i_in and answers each with one result word on
// o_out. Mode 1 accumulates a hemicube pixel: the color code minus one selects a patch
// bin, and the pixel's delta weight is computed on the fly (squared offsets, S squared,
// then a rounded 64-step bit-serial division) and added, saturating, to that bin and to
// the running total. The result word of a hit is offered once the shared divider is
// done; that of a miss skips the divider. Mode 2 reads one bin scaled by 65536 over the
// total through the same divider, or skips it when the total is zero or the entry index
// is out of range. Mode 0 clears the bin memory one entry per cycle and offers its
// result once that pass is done. The next word can be taken in the same cycle as the
// previous result is offered. After reset the same clearing pass runs before the first
// word is accepted. A finished result waits in an output register, so the next word is
// taken while it is still pending; the following result then holds off input until the
// receiver takes the first one. Write patch_count only while no word is in work.
`default_nettype none
module hemicube_form_factor_accumulator
    import hfa_pkg::*;
#(
    parameter int GRID_SIZE        = 64,
    parameter int MAX_PATCHES      = 1024,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wr_en,
    input  wire logic [PC_W-1:0] i_cfg_wr_data,
    hfa_in_if.sink               i_in,
    hfa_out_if.source            o_out
);
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The controller sequences each word; the datapath holds all arithmetic and storage.
    hfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    hfa_datapath #(
        .GRID_SIZE        (GRID_SIZE),
        .MAX_PATCHES      (MAX_PATCHES),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_mode          (i_in.mode),
        .i_side_face     (i_in.side_face),
        .i_pixel_row     (i_in.pixel_row),
        .i_pixel_column  (i_in.pixel_column),
        .i_color_code    (i_in.color_code),
        .i_entry_index   (i_in.entry_index),
        .o_form_factor   (o_out.form_factor),
        .o_pixel_counted (o_out.pixel_counted)
    );
endmodule
`default_nettype wire

@@ hw/rtl/hfa_checker.sv @@
// Port-level checks of the accumulator and their binding.
`default_nettype none
module hfa_checker
    import hfa_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            i_in_ready,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire logic [FF_W-1:0] i_form_factor,
    input wire logic            i_pixel_counted
);
    // A pending result word stays offered until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before it was taken");

    // A counted pixel never carries a form factor.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_pixel_counted && (i_form_factor != '0)))
        else $error("pixel_counted and form_factor both set");

    // Words are worked one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word accepted while one is in work");

    // The clearing pass after reset holds off input.
    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_in_ready)
        else $error("input accepted during the clearing pass");
endmodule

bind hemicube_form_factor_accumulator hfa_checker u_hfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_form_factor   (o_out.form_factor),
    .i_pixel_counted (o_out.pixel_counted)
);
`default_nettype wire
